/* rtl/efr_pkg.sv */
package efr_pkg;

  localparam int unsigned APB_ADDR_W = 5;
  localparam int unsigned APB_DATA_W = 32;
  localparam int unsigned Q_W = 16;
  localparam logic [15:0] Q_ONE = 16'hFFFF;
  localparam logic [15:0] Q_HALF = 16'd32767;
  localparam int unsigned DIV_STAGES = 8;

  typedef enum logic [1:0] {
    EASE_LINEAR     = 2'd0,
    EASE_SCURVE     = 2'd1,
    EASE_SINE       = 2'd2,
    EASE_LINEAR_ALT = 2'd3
  } ease_mode_e;

  typedef enum logic [2:0] {
    REG_EASE_MODE = 3'd0,
    REG_START_HZ  = 3'd1,
    REG_TARGET_HZ = 3'd2,
    REG_ACCEL_MS  = 3'd3,
    REG_DECEL_MS  = 3'd4,
    REG_MIN_HZ    = 3'd5,
    REG_MAX_HZ    = 3'd6
  } reg_idx_e;

  function automatic logic [15:0] sine_lut(input logic [4:0] idx);
    logic [15:0] y;
    case (idx)
      5'd0:    y = 16'd0;
      5'd1:    y = 16'd630;
      5'd2:    y = 16'd2494;
      5'd3:    y = 16'd5522;
      5'd4:    y = 16'd9598;
      5'd5:    y = 16'd14563;
      5'd6:    y = 16'd20228;
      5'd7:    y = 16'd26375;
      5'd8:    y = 16'd32768;
      5'd9:    y = 16'd39160;
      5'd10:   y = 16'd45307;
      5'd11:   y = 16'd50972;
      5'd12:   y = 16'd55938;
      5'd13:   y = 16'd60013;
      5'd14:   y = 16'd63041;
      5'd15:   y = 16'd64905;
      default: y = 16'd65535;
    endcase
    return y;
  endfunction

  // Floor division by 65535, exact for values below 2**50.
  function automatic logic [63:0] div_q_one(input logic [63:0] v);
    logic [63:0] q1;
    logic [63:0] r1;
    logic [63:0] q2;
    logic [63:0] r2;
    logic [63:0] q3;
    logic [63:0] r3;
    logic [63:0] q;
    q1 = v >> 16;
    r1 = {48'd0, v[15:0]} + q1;
    q2 = r1 >> 16;
    r2 = {48'd0, r1[15:0]} + q2;
    q3 = r2 >> 16;
    r3 = {48'd0, r2[15:0]} + q3;
    q = q1 + q2 + q3;
    if (r3 >= 64'd65535) begin
      q = q + 64'd1;
    end
    return q;
  endfunction

endpackage

/* rtl/efr_div.sv */
module efr_div #(
  parameter int unsigned DW = 24,
  parameter int unsigned SIDE_W = 1
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                valid_i,
  input  logic [DW+15:0]      num_i,
  input  logic [DW-1:0]       den_i,
  input  logic [SIDE_W-1:0]   side_i,
  output logic                valid_o,
  output logic [15:0]         quo_o,
  output logic [SIDE_W-1:0]   side_o
);

  localparam int unsigned STAGES = efr_pkg::DIV_STAGES;

  logic              valid_q [STAGES];
  logic [DW-1:0]     rem_q   [STAGES];
  logic [DW-1:0]     den_q   [STAGES];
  logic [15:0]       lq_q    [STAGES];
  logic [SIDE_W-1:0] side_q  [STAGES];

  for (genvar g = 0; g < STAGES; g++) begin : g_stage
    logic              vld_src;
    logic [DW-1:0]     rem_src;
    logic [DW-1:0]     den_src;
    logic [15:0]       lq_src;
    logic [SIDE_W-1:0] side_src;
    logic [DW-1:0]     rem_d;
    logic [15:0]       lq_d;

    if (g == 0) begin : g_first
      assign vld_src  = valid_i;
      assign rem_src  = num_i[DW+15:16];
      assign den_src  = den_i;
      assign lq_src   = num_i[15:0];
      assign side_src = side_i;
    end else begin : g_next
      assign vld_src  = valid_q[g-1];
      assign rem_src  = rem_q[g-1];
      assign den_src  = den_q[g-1];
      assign lq_src   = lq_q[g-1];
      assign side_src = side_q[g-1];
    end

    always_comb begin
      logic [DW-1:0] r;
      logic [15:0]   w;
      logic [DW:0]   t;
      r = rem_src;
      w = lq_src;
      for (int b = 0; b < 2; b++) begin
        t = {r, w[15]};
        w = {w[14:0], 1'b0};
        if (t >= {1'b0, den_src}) begin
          t = t - {1'b0, den_src};
          w[0] = 1'b1;
        end
        r = t[DW-1:0];
      end
      rem_d = r;
      lq_d = w;
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[g] <= 1'b0;
      end else begin
        valid_q[g] <= vld_src;
      end
    end

    always_ff @(posedge clk_i) begin
      rem_q[g]  <= rem_d;
      den_q[g]  <= den_src;
      lq_q[g]   <= lq_d;
      side_q[g] <= side_src;
    end
  end

  assign valid_o = valid_q[STAGES-1];
  assign quo_o   = lq_q[STAGES-1];
  assign side_o  = side_q[STAGES-1];

endmodule

/* rtl/efr_ease.sv */
module efr_ease #(
  parameter int unsigned SIDE_W = 1
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   valid_i,
  input  logic [15:0]            x_i,
  input  efr_pkg::ease_mode_e    mode_i,
  input  logic [SIDE_W-1:0]      side_i,
  output logic                   valid_o,
  output logic [15:0]            f_o,
  output logic [SIDE_W-1:0]      side_o
);

  logic                a_valid_q;
  efr_pkg::ease_mode_e a_mode_q;
  logic [15:0]         a_x_q;
  logic                a_low_q;
  logic [15:0]         a_d_q;
  logic [15:0]         a_y0_q;
  logic [15:0]         a_opa_q;
  logic [15:0]         a_opb_q;
  logic [SIDE_W-1:0]   a_side_q;

  logic                b_valid_q;
  efr_pkg::ease_mode_e b_mode_q;
  logic [15:0]         b_x_q;
  logic                b_low_q;
  logic [15:0]         b_d_q;
  logic [15:0]         b_y0_q;
  logic [31:0]         b_prod_q;
  logic [SIDE_W-1:0]   b_side_q;

  logic                c_valid_q;
  logic [15:0]         c_f_q;
  logic [SIDE_W-1:0]   c_side_q;

  logic        low_d;
  logic [15:0] d_d;
  logic [19:0] s_d;
  logic [63:0] sq_d;
  logic [4:0]  idx_d;
  logic [20:0] fr_d;
  logic [15:0] y0_d;
  logic [15:0] y1_d;
  logic [15:0] opa_d;
  logic [15:0] opb_d;

  always_comb begin
    low_d = (x_i < efr_pkg::Q_HALF);
    d_d   = x_i - efr_pkg::Q_HALF;
    s_d   = {x_i, 4'b0000};
    sq_d  = efr_pkg::div_q_one(64'(s_d));
    idx_d = sq_d[4:0];
    fr_d  = {1'b0, s_d} - ({idx_d, 16'h0000} - {16'h0000, idx_d});
    y0_d  = efr_pkg::sine_lut(idx_d);
    y1_d  = efr_pkg::sine_lut(idx_d + 5'd1);
    case (mode_i)
      efr_pkg::EASE_SINE: begin
        opa_d = y1_d - y0_d;
        opb_d = fr_d[15:0];
      end
      efr_pkg::EASE_SCURVE: begin
        opa_d = low_d ? x_i : d_d;
        opb_d = low_d ? x_i : d_d;
      end
      default: begin
        opa_d = x_i;
        opb_d = x_i;
      end
    endcase
  end

  logic [63:0] q_d;
  logic [17:0] hi_d;
  logic [15:0] f_d;

  always_comb begin
    if (b_mode_q == efr_pkg::EASE_SINE) begin
      q_d = efr_pkg::div_q_one(64'(b_prod_q));
    end else begin
      q_d = efr_pkg::div_q_one(64'({b_prod_q, 1'b0}));
    end
    hi_d = 18'(efr_pkg::Q_HALF) + 18'({b_d_q, 1'b0}) - q_d[17:0];
    case (b_mode_q)
      efr_pkg::EASE_SCURVE: begin
        if (b_low_q) begin
          f_d = q_d[15:0];
        end else if (hi_d > 18'(efr_pkg::Q_ONE)) begin
          f_d = efr_pkg::Q_ONE;
        end else begin
          f_d = hi_d[15:0];
        end
      end
      efr_pkg::EASE_SINE: begin
        f_d = b_y0_q + q_d[15:0];
      end
      default: begin
        f_d = b_x_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      b_valid_q <= 1'b0;
      c_valid_q <= 1'b0;
    end else begin
      a_valid_q <= valid_i;
      b_valid_q <= a_valid_q;
      c_valid_q <= b_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    a_mode_q <= mode_i;
    a_x_q    <= x_i;
    a_low_q  <= low_d;
    a_d_q    <= d_d;
    a_y0_q   <= y0_d;
    a_opa_q  <= opa_d;
    a_opb_q  <= opb_d;
    a_side_q <= side_i;
    b_mode_q <= a_mode_q;
    b_x_q    <= a_x_q;
    b_low_q  <= a_low_q;
    b_d_q    <= a_d_q;
    b_y0_q   <= a_y0_q;
    b_prod_q <= a_opa_q * a_opb_q;
    b_side_q <= a_side_q;
    c_f_q    <= f_d;
    c_side_q <= b_side_q;
  end

  assign valid_o = c_valid_q;
  assign f_o     = c_f_q;
  assign side_o  = c_side_q;

endmodule

/* rtl/efr_scale.sv */
module efr_scale #(
  parameter int unsigned FW = 24
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          valid_i,
  input  logic [15:0]   f_i,
  input  logic          bypass_i,
  input  logic [FW-1:0] from_i,
  input  logic [FW-1:0] to_i,
  input  logic [FW-1:0] min_i,
  input  logic [FW-1:0] max_i,
  output logic          valid_o,
  output logic [FW-1:0] freq_o
);

  function automatic logic [FW-1:0] clamp_f(input logic [FW-1:0] v, input logic [FW-1:0] lo,
                                            input logic [FW-1:0] hi);
    logic [FW-1:0] r;
    if (v < lo) begin
      r = lo;
    end else if (v > hi) begin
      r = hi;
    end else begin
      r = v;
    end
    return r;
  endfunction

  logic                 a_valid_q;
  logic signed [FW+17:0] a_prod_q;
  logic                 a_bypass_q;
  logic [FW-1:0]        a_from_q;
  logic [FW-1:0]        a_to_q;

  logic                 b_valid_q;
  logic signed [FW:0]   b_qs_q;
  logic                 b_bypass_q;
  logic [FW-1:0]        b_from_q;
  logic [FW-1:0]        b_to_q;

  logic                 c_valid_q;
  logic [FW-1:0]        c_freq_q;

  logic signed [FW:0]    delta_d;
  logic signed [FW+17:0] prod_d;

  always_comb begin
    delta_d = $signed({1'b0, to_i}) - $signed({1'b0, from_i});
    prod_d  = delta_d * $signed({1'b0, f_i});
  end

  logic [FW+17:0] mag_d;
  logic [63:0]    quo_d;
  logic [FW:0]    qm_d;
  logic [FW:0]    qs_d;

  always_comb begin
    mag_d = a_prod_q[FW+17] ? (FW+18)'(-a_prod_q) : a_prod_q;
    quo_d = efr_pkg::div_q_one(64'(mag_d));
    qm_d  = {1'b0, quo_d[FW-1:0]};
    qs_d  = a_prod_q[FW+17] ? (FW+1)'(-qm_d) : qm_d;
  end

  logic signed [FW+1:0] sum_d;
  logic [FW-1:0]        res_d;

  always_comb begin
    sum_d = $signed({2'b00, b_from_q}) + $signed({b_qs_q[FW], b_qs_q});
    if (b_bypass_q) begin
      res_d = clamp_f(b_to_q, min_i, max_i);
    end else begin
      res_d = clamp_f(sum_d[FW-1:0], min_i, max_i);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      b_valid_q <= 1'b0;
      c_valid_q <= 1'b0;
    end else begin
      a_valid_q <= valid_i;
      b_valid_q <= a_valid_q;
      c_valid_q <= b_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    a_prod_q   <= prod_d;
    a_bypass_q <= bypass_i;
    a_from_q   <= from_i;
    a_to_q     <= to_i;
    b_qs_q     <= $signed(qs_d);
    b_bypass_q <= a_bypass_q;
    b_from_q   <= a_from_q;
    b_to_q     <= a_to_q;
    c_freq_q   <= res_d;
  end

  assign valid_o = c_valid_q;
  assign freq_o  = c_freq_q;

endmodule

/* rtl/eased_frequency_ramp_unit.sv */
// Eased frequency ramp: maps an elapsed time in ms to a commanded pulse frequency.
// Input channel: drive elapsed_time_ms_i and pulse start; the word is taken at
// every rising edge where start is high and busy is low. busy never rises, so a
// new word can be taken in every cycle.
// Output channel: freq_out_hz_o is valid for exactly one cycle while
// freq_valid_o is high. The receiver cannot stall the block.
// The result passes through 15 register stages and throughput is one word per
// cycle: one stage of limit clamping and ramp selection, an 8-stage
// restoring divider retiring two quotient bits per stage, three easing stages
// and three scaling and clamping stages.
// Configuration goes through the APB port; registers sit at byte address
// 4*index. Write them only while no word is in flight (not enforced).
// Reset clears the pipeline valid bits and sets all registers to their reset
// values, with max_hz at all ones. No result is produced after reset until a
// word is accepted.
module eased_frequency_ramp_unit #(
  parameter int unsigned FREQ_BITS = 24,
  parameter int unsigned TIME_BITS = 24
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start,
  output logic                                busy,
  input  logic [TIME_BITS-1:0]                elapsed_time_ms_i,
  output logic                                freq_valid_o,
  output logic [FREQ_BITS-1:0]                freq_out_hz_o,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [efr_pkg::APB_ADDR_W-1:0]      paddr,
  input  logic [efr_pkg::APB_DATA_W-1:0]      pwdata,
  output logic [efr_pkg::APB_DATA_W-1:0]      prdata,
  output logic                                pready
);

  localparam int unsigned FW = FREQ_BITS;
  localparam int unsigned TW = TIME_BITS;
  localparam int unsigned DIV_SIDE_W = 2 * FW + 3;
  localparam int unsigned EASE_SIDE_W = 2 * FW + 1;

  efr_pkg::ease_mode_e ease_mode_q;
  logic [FW-1:0]       start_hz_q;
  logic [FW-1:0]       target_hz_q;
  logic [TW-1:0]       accel_ms_q;
  logic [TW-1:0]       decel_ms_q;
  logic [FW-1:0]       min_hz_q;
  logic [FW-1:0]       max_hz_q;

  efr_pkg::reg_idx_e reg_idx;
  logic              wr_en;

  assign pready  = 1'b1;
  assign busy    = 1'b0;
  assign reg_idx = efr_pkg::reg_idx_e'(paddr[4:2]);
  assign wr_en   = psel & penable & pwrite & pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ease_mode_q <= efr_pkg::EASE_LINEAR;
      start_hz_q  <= '0;
      target_hz_q <= '0;
      accel_ms_q  <= '0;
      decel_ms_q  <= '0;
      min_hz_q    <= '0;
      max_hz_q    <= '1;
    end else if (wr_en) begin
      case (reg_idx)
        efr_pkg::REG_EASE_MODE: ease_mode_q <= efr_pkg::ease_mode_e'(pwdata[1:0]);
        efr_pkg::REG_START_HZ:  start_hz_q  <= pwdata[FW-1:0];
        efr_pkg::REG_TARGET_HZ: target_hz_q <= pwdata[FW-1:0];
        efr_pkg::REG_ACCEL_MS:  accel_ms_q  <= pwdata[TW-1:0];
        efr_pkg::REG_DECEL_MS:  decel_ms_q  <= pwdata[TW-1:0];
        efr_pkg::REG_MIN_HZ:    min_hz_q    <= pwdata[FW-1:0];
        efr_pkg::REG_MAX_HZ:    max_hz_q    <= pwdata[FW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      efr_pkg::REG_EASE_MODE: prdata = 32'(ease_mode_q);
      efr_pkg::REG_START_HZ:  prdata = 32'(start_hz_q);
      efr_pkg::REG_TARGET_HZ: prdata = 32'(target_hz_q);
      efr_pkg::REG_ACCEL_MS:  prdata = 32'(accel_ms_q);
      efr_pkg::REG_DECEL_MS:  prdata = 32'(decel_ms_q);
      efr_pkg::REG_MIN_HZ:    prdata = 32'(min_hz_q);
      efr_pkg::REG_MAX_HZ:    prdata = 32'(max_hz_q);
      default:                prdata = '0;
    endcase
  end

  function automatic logic [FW-1:0] clamp_f(input logic [FW-1:0] v, input logic [FW-1:0] lo,
                                            input logic [FW-1:0] hi);
    logic [FW-1:0] r;
    if (v < lo) begin
      r = lo;
    end else if (v > hi) begin
      r = hi;
    end else begin
      r = v;
    end
    return r;
  endfunction

  logic [FW-1:0]    from_d;
  logic [FW-1:0]    to_d;
  logic [TW-1:0]    ramp_d;
  logic             bypass_d;
  logic [TW+15:0]   num_d;

  always_comb begin
    from_d = clamp_f(start_hz_q, min_hz_q, max_hz_q);
    to_d   = clamp_f(target_hz_q, min_hz_q, max_hz_q);
    if (to_d == from_d) begin
      ramp_d = '0;
    end else if (to_d > from_d) begin
      ramp_d = accel_ms_q;
    end else begin
      ramp_d = decel_ms_q;
    end
    bypass_d = (ramp_d == '0) || (elapsed_time_ms_i >= ramp_d);
    num_d    = {elapsed_time_ms_i, 16'h0000} - {16'h0000, elapsed_time_ms_i};
  end

  logic                  in_valid_q;
  logic [TW+15:0]        in_num_q;
  logic [TW-1:0]         in_ramp_q;
  logic [DIV_SIDE_W-1:0] in_side_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= start & ~busy;
    end
  end

  always_ff @(posedge clk_i) begin
    in_num_q  <= num_d;
    in_ramp_q <= ramp_d;
    in_side_q <= {ease_mode_q, bypass_d, from_d, to_d};
  end

  logic                  div_valid;
  logic [15:0]           div_quo;
  logic [DIV_SIDE_W-1:0] div_side;

  efr_div #(
    .DW     (TW),
    .SIDE_W (DIV_SIDE_W)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_valid_q),
    .num_i   (in_num_q),
    .den_i   (in_ramp_q),
    .side_i  (in_side_q),
    .valid_o (div_valid),
    .quo_o   (div_quo),
    .side_o  (div_side)
  );

  logic                   ease_valid;
  logic [15:0]            ease_f;
  logic [EASE_SIDE_W-1:0] ease_side;

  efr_ease #(
    .SIDE_W (EASE_SIDE_W)
  ) u_ease (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (div_valid),
    .x_i     (div_quo),
    .mode_i  (efr_pkg::ease_mode_e'(div_side[DIV_SIDE_W-1 -: 2])),
    .side_i  (div_side[EASE_SIDE_W-1:0]),
    .valid_o (ease_valid),
    .f_o     (ease_f),
    .side_o  (ease_side)
  );

  efr_scale #(
    .FW (FW)
  ) u_scale (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (ease_valid),
    .f_i      (ease_f),
    .bypass_i (ease_side[2*FW]),
    .from_i   (ease_side[2*FW-1:FW]),
    .to_i     (ease_side[FW-1:0]),
    .min_i    (min_hz_q),
    .max_i    (max_hz_q),
    .valid_o  (freq_valid_o),
    .freq_o   (freq_out_hz_o)
  );

endmodule
